FILE: rtl/core/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef struct packed {
        logic look;
        logic load;
    } t_cell_ctrl;

endpackage

FILE: rtl/core/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// One recency slot: valid mark, key and value, key compare, load from the
// younger neighbor.
// ----------------------------------------------------------------------------
module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctrl             i_ctrl,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic                   i_prev_valid,
    input  logic [KEY_WIDTH-1:0]   i_prev_key,
    input  logic [VALUE_WIDTH-1:0] i_prev_value,
    output logic                   o_valid,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_match
);

    logic                   r_valid;
    logic                   r_match;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.look) begin
                r_match <= r_valid && (r_key == i_key);
            end
            if (i_ctrl.load) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule

FILE: rtl/core/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with LRU replacement, kept as a chain
// of cells ordered from most to least recent.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction passes the compare state, then the shift
// state; its result is registered as the shift commits, and a new one can
// be accepted only then. While the result is stalled, the shift state holds.
// Reset: valid marks and fill clear, capacity returns to 16, no result held.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CAP_W-1:0]       i_cfg_capacity,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_cmd,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VALUE_WIDTH-1:0] o_read_value,
    output logic                   o_hit,
    output logic                   o_evicted,
    output logic [KEY_WIDTH-1:0]   o_evicted_key
);

    localparam int FW = $clog2(ENTRIES + 1);
    localparam int CW = (FW > CAP_W) ? FW : CAP_W;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_UPD} t_state;

    t_state                 r_state;
    logic [CAP_W-1:0]       r_capacity;
    logic [FW-1:0]          r_fill;
    logic                   r_cmd;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_read_value;
    logic                   r_out_hit;
    logic                   r_out_evicted;
    logic [KEY_WIDTH-1:0]   r_out_evicted_key;

    logic                   commit;
    logic                   accept;
    logic                   hit;
    logic                   full;
    logic                   is_set;
    logic                   insert;
    logic                   evict;
    logic [CW-1:0]          cap_ext;
    logic [CW-1:0]          eff_cap;
    logic [VALUE_WIDTH-1:0] hit_value;
    logic [KEY_WIDTH-1:0]   tail_key;
    logic [VALUE_WIDTH-1:0] head_value;
    logic [VALUE_WIDTH-1:0] n_read_value;
    logic [KEY_WIDTH-1:0]   n_evicted_key;

    logic [ENTRIES-1:0]     match_vec;
    logic [ENTRIES-1:0]     valid_vec;
    logic [ENTRIES-1:0]     tail_vec;
    logic [ENTRIES-1:0]     shift_vec;
    logic [KEY_WIDTH-1:0]   cell_key   [ENTRIES];
    logic [VALUE_WIDTH-1:0] cell_value [ENTRIES];
    logic [ENTRIES-1:0]     val_col    [VALUE_WIDTH];
    logic [ENTRIES-1:0]     key_col    [KEY_WIDTH];

    assign commit = (r_state == S_UPD) && (!r_out_valid || !i_stall);
    assign o_stall = !((r_state == S_IDLE) || commit);
    assign accept  = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cap_ext = CW'(r_capacity);
        if (cap_ext == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > CW'(ENTRIES)) begin
            eff_cap = CW'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign hit    = |match_vec;
    assign full   = CW'(r_fill) >= eff_cap;
    assign is_set = (r_cmd == CMD_SET);
    assign insert = is_set && !hit && !full;
    assign evict  = is_set && !hit && full;
    assign head_value = is_set ? r_value : hit_value;

    genvar gi, gb;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            t_cell_ctrl             ctrl;
            logic                   prev_valid;
            logic [KEY_WIDTH-1:0]   prev_key;
            logic [VALUE_WIDTH-1:0] prev_value;
            logic                   ins_shift;

            if (gi == 0) begin : g_head
                assign prev_valid = 1'b1;
                assign prev_key   = r_key;
                assign prev_value = head_value;
                assign ins_shift  = 1'b1;
            end else begin : g_body
                assign prev_valid = valid_vec[gi-1];
                assign prev_key   = cell_key[gi-1];
                assign prev_value = cell_value[gi-1];
                assign ins_shift  = valid_vec[gi-1];
            end

            if (gi == ENTRIES - 1) begin : g_last
                assign tail_vec[gi] = valid_vec[gi];
            end else begin : g_mid
                assign tail_vec[gi] = valid_vec[gi] && !valid_vec[gi+1];
            end

            assign shift_vec[gi] = hit    ? (|match_vec[ENTRIES-1:gi]) :
                                   evict  ? valid_vec[gi] :
                                   insert ? ins_shift : 1'b0;

            assign ctrl.look = (r_state == S_LOOK);
            assign ctrl.load = commit && shift_vec[gi];

            lkvc_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_key        (r_key),
                .i_prev_valid (prev_valid),
                .i_prev_key   (prev_key),
                .i_prev_value (prev_value),
                .o_valid      (valid_vec[gi]),
                .o_key        (cell_key[gi]),
                .o_value      (cell_value[gi]),
                .o_match      (match_vec[gi])
            );

            for (gb = 0; gb < VALUE_WIDTH; gb++) begin : g_vbit
                assign val_col[gb][gi] = match_vec[gi] & cell_value[gi][gb];
            end
            for (gb = 0; gb < KEY_WIDTH; gb++) begin : g_kbit
                assign key_col[gb][gi] = tail_vec[gi] & cell_key[gi][gb];
            end
        end

        for (gb = 0; gb < VALUE_WIDTH; gb++) begin : g_vred
            assign hit_value[gb] = |val_col[gb];
        end
        for (gb = 0; gb < KEY_WIDTH; gb++) begin : g_kred
            assign tail_key[gb] = |key_col[gb];
        end
    endgenerate

    assign n_read_value  = is_set ? '0 : (hit ? hit_value : '1);
    assign n_evicted_key = evict ? tail_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_fill     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_capacity;
            end
            if (commit && insert) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (commit) begin
                        r_out_valid       <= 1'b1;
                        r_out_read_value  <= n_read_value;
                        r_out_hit         <= hit;
                        r_out_evicted     <= evict;
                        r_out_evicted_key <= n_evicted_key;
                        r_state           <= accept ? S_LOOK : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out_read_value;
    assign o_hit         = r_out_hit;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evicted_key;

    a_fill_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_fill))
        else $error("fill count does not match valid cells");

    a_match_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(match_vec))
        else $error("key present in more than one cell");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction flagged together");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tail_vec))
        else $error("valid cells are not contiguous from the head");

endmodule
